// File: rtl/core/itd_pkg.sv
// Shared types and constants for the integer to decimal ASCII unit.
`timescale 1ns / 1ps

package itd_pkg;

   localparam int VALUE_W    = 64;
   localparam int NUM_DIGITS = 20;
   localparam int DIGIT_IDX_W = 5;
   localparam int STEP_W     = 6;

   localparam logic [1:0] OP_U32 = 2'd0;
   localparam logic [1:0] OP_S32 = 2'd1;
   localparam logic [1:0] OP_U64 = 2'd2;
   localparam logic [1:0] OP_S64 = 2'd3;

   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] MINUS_SIGN = 8'h2d;

   // one classified number waiting for conversion
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } item_type;

endpackage

// File: rtl/core/itd_front.sv
// Front end: takes a request beat, reads the operation and forms sign and magnitude.
`timescale 1ns / 1ps

module itd_front (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [itd_pkg::VALUE_W-1:0] req_value,
   output logic                        push_valid,
   input  logic                        push_full,
   output itd_pkg::item_type           push_item
);

   logic [31:0]                 neg32;
   logic [itd_pkg::VALUE_W-1:0] neg64;

   assign neg32 = ~req_value[31:0] + 32'd1;
   assign neg64 = ~req_value + 64'd1;

   always_comb begin
      push_item.neg = 1'b0;
      push_item.mag = req_value;
      case (req_operation)
         itd_pkg::OP_U32: begin
            push_item.mag = {32'd0, req_value[31:0]};
         end
         itd_pkg::OP_S32: begin
            push_item.neg = req_value[31];
            // two's complement of 0x80000000 is itself, which is the right magnitude
            push_item.mag = req_value[31] ? {32'd0, neg32} : {32'd0, req_value[31:0]};
         end
         itd_pkg::OP_U64: begin
            push_item.mag = req_value;
         end
         default: begin
            push_item.neg = req_value[63];
            push_item.mag = req_value[63] ? neg64 : req_value;
         end
      endcase
   end

   assign push_valid = req_valid;
   assign req_stall  = push_full;

endmodule

// File: rtl/core/itd_queue.sv
// Two-entry queue between the front end and the converter.
`timescale 1ns / 1ps

module itd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_full,
   input  itd_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop,
   output itd_pkg::item_type pop_item
);

   itd_pkg::item_type mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_full = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/itd_back.sv
// Back end: shift-and-add-3 conversion, one bit per cycle, then one character per beat.
`timescale 1ns / 1ps

module itd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop,
   input  itd_pkg::item_type pop_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_character,
   output logic              rsp_last
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_FIND  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic                            neg_ff, neg_in;
   logic [itd_pkg::VALUE_W-1:0]     bin_ff, bin_in;
   logic [3:0]                      bcd_ff [itd_pkg::NUM_DIGITS];
   logic [3:0]                      bcd_in [itd_pkg::NUM_DIGITS];
   logic [3:0]                      adj    [itd_pkg::NUM_DIGITS];
   logic [itd_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [itd_pkg::DIGIT_IDX_W-1:0] ptr_ff, ptr_in;
   logic [itd_pkg::DIGIT_IDX_W-1:0] top_digit;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      char_ff, char_in;
   logic                            last_ff, last_in;
   logic                            out_free;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < itd_pkg::NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   // highest nonzero digit, zero when the number is zero
   always_comb begin
      top_digit = '0;
      for (int i = 0; i < itd_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            top_digit = itd_pkg::DIGIT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      ptr_in       = ptr_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      pop          = 1'b0;
      for (int i = 0; i < itd_pkg::NUM_DIGITS; i++) begin
         bcd_in[i] = bcd_ff[i];
      end
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               neg_in   = pop_item.neg;
               bin_in   = pop_item.mag;
               step_in  = '0;
               state_in = ST_CONV;
               for (int i = 0; i < itd_pkg::NUM_DIGITS; i++) begin
                  bcd_in[i] = 4'd0;
               end
            end
         end
         ST_CONV: begin
            bcd_in[0] = {adj[0][2:0], bin_ff[itd_pkg::VALUE_W-1]};
            for (int i = 1; i < itd_pkg::NUM_DIGITS; i++) begin
               bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
            bin_in  = {bin_ff[itd_pkg::VALUE_W-2:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            ptr_in   = top_digit;
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = itd_pkg::MINUS_SIGN;
               last_in      = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = itd_pkg::DIGIT_ZERO + {4'd0, bcd_ff[ptr_ff]};
               last_in      = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - 5'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      bin_ff  <= bin_in;
      step_ff <= step_in;
      ptr_ff  <= ptr_in;
      char_ff <= char_in;
      last_ff <= last_in;
      for (int i = 0; i < itd_pkg::NUM_DIGITS; i++) begin
         bcd_ff[i] <= bcd_in[i];
      end
   end

endmodule

// File: rtl/core/integer_to_decimal_ascii_unit.sv
// Top level of the integer to decimal ASCII unit.
`timescale 1ns / 1ps

// Converts one integer per request beat to decimal ASCII text, one character per
// response beat, most significant digit first, with rsp_last on the final digit.
// req_operation picks unsigned 32-bit, signed 32-bit, unsigned 64-bit or signed
// 64-bit; negative values start with '-'. In the converter a number goes through
// a queue pop, 64 shift-and-add-3 steps and a leading-digit search, and it then
// gives one character per response beat (1 to 20) when responses are not stalled.
// The single shift-and-add-3 converter takes a new number only after the last
// character of the previous one; a two-entry queue in front of it absorbs up to two further requests.

module integer_to_decimal_ascii_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [itd_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last
);

   logic              push_valid;
   logic              push_full;
   itd_pkg::item_type push_item;
   logic              pop_valid;
   logic              pop;
   itd_pkg::item_type pop_item;

   itd_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     (req_value),
      .push_valid    (push_valid),
      .push_full     (push_full),
      .push_item     (push_item)
   );

   itd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   itd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop           (pop),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule
